>>> src/hlpd_pkg.sv
`default_nettype none

package hlpd_pkg;

  // input item kinds
  localparam logic [1:0] OP_CMD   = 2'd0;
  localparam logic [1:0] OP_PTICK = 2'd1;
  localparam logic [1:0] OP_PWM   = 2'd2;

  // command bytes
  localparam logic [7:0] CMD_LIGHT_LO   = 8'h10;
  localparam logic [7:0] CMD_LIGHT_HI   = 8'h11;
  localparam logic [7:0] CMD_BEEP       = 8'h20;
  localparam logic [7:0] CMD_BOOP       = 8'h21;
  localparam logic [7:0] CMD_LED_OFF    = 8'h30;
  localparam logic [7:0] CMD_LED_ON     = 8'h31;
  localparam logic [7:0] CMD_LED_PULSE  = 8'h32;
  localparam logic [7:0] CMD_LED_BLINKB = 8'h34;

  // classified work codes passed from front to back
  localparam logic [3:0] K_NOP         = 4'd0;
  localparam logic [3:0] K_LIGHT_LO    = 4'd1;
  localparam logic [3:0] K_LIGHT_HI    = 4'd2;
  localparam logic [3:0] K_BEEP        = 4'd3;
  localparam logic [3:0] K_BOOP        = 4'd4;
  localparam logic [3:0] K_LED_SET     = 4'd5;
  localparam logic [3:0] K_LED_RESTART = 4'd6;
  localparam logic [3:0] K_PTICK       = 4'd7;
  localparam logic [3:0] K_PWM         = 4'd8;

  // led modes
  localparam logic [2:0] LED_OFF    = 3'd0;
  localparam logic [2:0] LED_ON     = 3'd1;
  localparam logic [2:0] LED_PULSE  = 3'd2;
  localparam logic [2:0] LED_BLINKA = 3'd3;
  localparam logic [2:0] LED_BLINKB = 3'd4;

  // vibration patterns
  localparam logic [1:0] VIBE_IDLE = 2'd0;
  localparam logic [1:0] VIBE_BEEP = 2'd1;
  localparam logic [1:0] VIBE_BOOP = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_BEEP_TICKS = 2'd0;
  localparam logic [1:0] CFG_BEEP_GAP   = 2'd1;
  localparam logic [1:0] CFG_BOOP_TICKS = 2'd2;

  localparam int unsigned CFG_W = 14;

  localparam logic [11:0] BEEP_TICKS_RST = 12'd50;
  localparam logic [11:0] BEEP_GAP_RST   = 12'd50;
  localparam logic [13:0] BOOP_TICKS_RST = 14'd200;

  localparam logic [11:0] PULSE_CYCLE = 12'd2500;
  localparam logic [11:0] BLINK_CYCLE = 12'd250;
  localparam logic [4:0]  PULSE_STEP  = 5'd20;
  localparam logic [4:0]  BLINK_STEP  = 5'd10;
  localparam logic [8:0]  DUTY_FULL   = 9'd256;

  typedef struct packed {
    logic [3:0] kind;
    logic [2:0] led_mode;
  } hlpd_item_t;

  typedef struct packed {
    logic light;
    logic vibe;
    logic led_a;
    logic led_b;
  } hlpd_pins_t;

endpackage

`default_nettype wire

>>> src/hlpd_front.sv
`default_nettype none

module hlpd_front import hlpd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire logic [1:0] op,
  input  wire logic [7:0] cmd,
  output logic            full,
  output logic            q_valid,
  output hlpd_item_t      q_item,
  input  wire logic       q_pop
);

  hlpd_item_t item;
  hlpd_item_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       wr_en;
  logic       rd_en;

  // classify the incoming beat
  always_comb begin
    item.kind     = K_NOP;
    item.led_mode = cmd[2:0];
    case (op)
      OP_CMD: begin
        case (cmd) inside
          CMD_LIGHT_LO:                   item.kind = K_LIGHT_LO;
          CMD_LIGHT_HI:                   item.kind = K_LIGHT_HI;
          CMD_BEEP:                       item.kind = K_BEEP;
          CMD_BOOP:                       item.kind = K_BOOP;
          CMD_LED_OFF, CMD_LED_ON:        item.kind = K_LED_SET;
          [CMD_LED_PULSE:CMD_LED_BLINKB]: item.kind = K_LED_RESTART;
          default:                        item.kind = K_NOP;
        endcase
      end
      OP_PTICK: item.kind = K_PTICK;
      OP_PWM:   item.kind = K_PWM;
      default:  item.kind = K_NOP;
    endcase
  end

  assign full    = (count_r == 2'd2);
  assign q_valid = (count_r != 2'd0);
  assign q_item  = mem_r[rd_ptr_r];
  assign wr_en   = push && !full;
  assign rd_en   = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_en ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = rd_en ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= item;
    end
  end

endmodule

`default_nettype wire

>>> src/hlpd_back.sv
`default_nettype none

module hlpd_back import hlpd_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  input  wire logic             q_valid,
  input  wire hlpd_item_t       q_item,
  output logic                  q_pop,
  input  wire logic             res_full,
  output logic                  res_push,
  output hlpd_pins_t            res_pins
);

  // configuration and derived thresholds; each is refreshed when a register it depends on is written
  logic [11:0] beep_ticks_r;
  logic [11:0] beep_gap_r;
  logic [13:0] boop_ticks_r;
  logic [12:0] beep_end1_r;
  logic [13:0] beep_end2_r;
  logic [13:0] beep_done_r;

  logic [15:0] tick_count_r, tick_count_nxt;
  logic [15:0] vibe_start_r, vibe_start_nxt;
  logic [1:0]  vibe_mode_r, vibe_mode_nxt;
  logic [2:0]  led_mode_r, led_mode_nxt;
  logic [11:0] pattern_count_r, pattern_count_nxt;
  logic [4:0]  step_cnt_r, step_cnt_nxt;
  logic [8:0]  duty_r, duty_nxt;
  logic [7:0]  pwm_phase_r, pwm_phase_nxt;
  hlpd_pins_t  pins_r, pins_nxt;

  logic        go;
  logic [15:0] elapsed;
  logic        beep_on;
  logic [11:0] cycle_len;
  logic [4:0]  step_len;
  logic [12:0] pc_inc;
  logic [4:0]  step_inc;
  logic [10:0] duty_x3;
  logic        pwm_level;

  assign go       = q_valid && !res_full;
  assign q_pop    = go;
  assign res_push = go;
  assign res_pins = pins_nxt;

  assign elapsed = tick_count_r - vibe_start_r;
  assign beep_on = (elapsed < {4'd0, beep_ticks_r}) ||
                   ((elapsed > {3'd0, beep_end1_r}) && (elapsed < {2'd0, beep_end2_r}));
  assign cycle_len = (led_mode_r == LED_PULSE) ? PULSE_CYCLE : BLINK_CYCLE;
  assign step_len  = (led_mode_r == LED_PULSE) ? PULSE_STEP : BLINK_STEP;
  assign pc_inc    = {1'b0, pattern_count_r} + 13'd1;
  assign step_inc  = step_cnt_r + 5'd1;
  assign duty_x3   = {2'b00, duty_r} + {1'b0, duty_r, 1'b0};
  assign pwm_level = !({1'b0, pwm_phase_r} < duty_r);

  always_comb begin
    tick_count_nxt    = tick_count_r;
    vibe_start_nxt    = vibe_start_r;
    vibe_mode_nxt     = vibe_mode_r;
    led_mode_nxt      = led_mode_r;
    pattern_count_nxt = pattern_count_r;
    step_cnt_nxt      = step_cnt_r;
    duty_nxt          = duty_r;
    pwm_phase_nxt     = pwm_phase_r;
    pins_nxt          = pins_r;
    case (q_item.kind)
      K_LIGHT_LO: pins_nxt.light = 1'b0;
      K_LIGHT_HI: pins_nxt.light = 1'b1;
      K_BEEP: begin
        if (vibe_mode_r == VIBE_IDLE) begin
          vibe_mode_nxt  = VIBE_BEEP;
          vibe_start_nxt = tick_count_r;
        end
      end
      K_BOOP: begin
        vibe_mode_nxt  = VIBE_BOOP;
        vibe_start_nxt = tick_count_r;
      end
      K_LED_SET: led_mode_nxt = q_item.led_mode;
      K_LED_RESTART: begin
        led_mode_nxt      = q_item.led_mode;
        pattern_count_nxt = 12'd0;
        step_cnt_nxt      = 5'd0;
        duty_nxt          = DUTY_FULL;
        pwm_phase_nxt     = 8'd0;
      end
      K_PTICK: begin
        case (vibe_mode_r)
          VIBE_BEEP: begin
            pins_nxt.vibe = beep_on;
            if (elapsed > {2'd0, beep_done_r}) begin
              vibe_mode_nxt = VIBE_IDLE;
            end
          end
          VIBE_BOOP: begin
            pins_nxt.vibe = (elapsed < {2'd0, boop_ticks_r});
            if (elapsed > {2'd0, boop_ticks_r}) begin
              vibe_mode_nxt = VIBE_IDLE;
            end
          end
          default: ;
        endcase
        case (led_mode_r) inside
          LED_OFF: begin
            pins_nxt.led_a = 1'b1;
            pins_nxt.led_b = 1'b1;
          end
          LED_ON: begin
            pins_nxt.led_a = 1'b0;
            pins_nxt.led_b = 1'b0;
          end
          [LED_PULSE:LED_BLINKB]: begin
            if (pattern_count_r == 12'd0) begin
              duty_nxt = DUTY_FULL;
            end else if (step_cnt_r == 5'd0) begin
              duty_nxt = duty_x3[10:2];
            end
            // step counter tracks pattern_count modulo the decay step
            if (pc_inc >= {1'b0, cycle_len}) begin
              pattern_count_nxt = 12'd0;
              step_cnt_nxt      = 5'd0;
            end else begin
              pattern_count_nxt = pc_inc[11:0];
              step_cnt_nxt      = (step_inc == step_len) ? 5'd0 : step_inc;
            end
          end
          default: ;
        endcase
        tick_count_nxt = tick_count_r + 16'd1;
      end
      K_PWM: begin
        case (led_mode_r)
          LED_PULSE: begin
            pins_nxt.led_a = pwm_level;
            pins_nxt.led_b = pwm_level;
          end
          LED_BLINKA: pins_nxt.led_a = pwm_level;
          LED_BLINKB: pins_nxt.led_b = pwm_level;
          default: ;
        endcase
        pwm_phase_nxt = pwm_phase_r + 8'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beep_ticks_r <= BEEP_TICKS_RST;
      beep_gap_r   <= BEEP_GAP_RST;
      boop_ticks_r <= BOOP_TICKS_RST;
      beep_end1_r  <= {1'b0, BEEP_TICKS_RST} + {1'b0, BEEP_GAP_RST};
      beep_end2_r  <= {1'b0, BEEP_TICKS_RST, 1'b0} + {2'b00, BEEP_GAP_RST};
      beep_done_r  <= {1'b0, BEEP_TICKS_RST, 1'b0} + {2'b00, BEEP_TICKS_RST};
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BEEP_TICKS: begin
          beep_ticks_r <= cfg_wdata[11:0];
          beep_end1_r  <= {1'b0, cfg_wdata[11:0]} + {1'b0, beep_gap_r};
          beep_end2_r  <= {1'b0, cfg_wdata[11:0], 1'b0} + {2'b00, beep_gap_r};
          beep_done_r  <= {1'b0, cfg_wdata[11:0], 1'b0} + {2'b00, cfg_wdata[11:0]};
        end
        CFG_BEEP_GAP: begin
          beep_gap_r  <= cfg_wdata[11:0];
          beep_end1_r <= {1'b0, beep_ticks_r} + {1'b0, cfg_wdata[11:0]};
          beep_end2_r <= {1'b0, beep_ticks_r, 1'b0} + {2'b00, cfg_wdata[11:0]};
        end
        CFG_BOOP_TICKS: boop_ticks_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_count_r    <= 16'd0;
      vibe_start_r    <= 16'd0;
      vibe_mode_r     <= VIBE_IDLE;
      led_mode_r      <= LED_BLINKA;
      pattern_count_r <= 12'd0;
      step_cnt_r      <= 5'd0;
      duty_r          <= 9'd0;
      pwm_phase_r     <= 8'd0;
      pins_r          <= '{light: 1'b0, vibe: 1'b0, led_a: 1'b1, led_b: 1'b1};
    end else if (go) begin
      tick_count_r    <= tick_count_nxt;
      vibe_start_r    <= vibe_start_nxt;
      vibe_mode_r     <= vibe_mode_nxt;
      led_mode_r      <= led_mode_nxt;
      pattern_count_r <= pattern_count_nxt;
      step_cnt_r      <= step_cnt_nxt;
      duty_r          <= duty_nxt;
      pwm_phase_r     <= pwm_phase_nxt;
      pins_r          <= pins_nxt;
    end
  end

endmodule

`default_nettype wire

>>> src/hlpd_outq.sv
`default_nettype none

module hlpd_outq import hlpd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire hlpd_pins_t push_pins,
  output logic      full,
  output logic      empty,
  input  wire logic pop,
  output hlpd_pins_t head_pins
);

  hlpd_pins_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       wr_en;
  logic       rd_en;

  assign full      = (count_r == 2'd2);
  assign empty     = (count_r == 2'd0);
  assign head_pins = mem_r[rd_ptr_r];
  assign wr_en     = push && !full;
  assign rd_en     = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_en ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = rd_en ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= push_pins;
    end
  end

endmodule

`default_nettype wire

>>> src/haptic_and_led_pattern_driver.sv
// an accepted beat is queued, executed, then its pins are queued for the out_ ports
// throughput: one item per cycle while the result queue has room; a two-entry queue sits
// between decode and execute, and a two-entry result queue decouples execute from out_pop
// reset (synchronous, rst_n low): queues empty, light and motor low, both leds off,
// led mode blink A, beep 50/50 and boop 200 pattern ticks
`default_nettype none

module haptic_and_led_pattern_driver import hlpd_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_push,
  output logic                  in_full,
  input  wire logic [1:0]       in_op,
  input  wire logic [7:0]       in_cmd,
  output logic                  out_empty,
  input  wire logic             out_pop,
  output logic                  out_light_level,
  output logic                  out_vibe_level,
  output logic                  out_led_a_level,
  output logic                  out_led_b_level,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  hlpd_item_t q_item;
  logic       q_valid;
  logic       q_pop;
  logic       res_push;
  logic       res_full;
  hlpd_pins_t res_pins;
  hlpd_pins_t head_pins;

  hlpd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .op      (in_op),
    .cmd     (in_cmd),
    .full    (in_full),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  hlpd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_pins  (res_pins)
  );

  hlpd_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_pins (res_pins),
    .full      (res_full),
    .empty     (out_empty),
    .pop       (out_pop),
    .head_pins (head_pins)
  );

  assign out_light_level = head_pins.light;
  assign out_vibe_level  = head_pins.vibe;
  assign out_led_a_level = head_pins.led_a;
  assign out_led_b_level = head_pins.led_b;

endmodule

`default_nettype wire

>>> src/hlpd_checker.sv
`default_nettype none

module hlpd_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_push,
  input wire logic in_full,
  input wire logic out_empty,
  input wire logic out_pop,
  input wire logic out_light_level,
  input wire logic out_vibe_level,
  input wire logic out_led_a_level,
  input wire logic out_led_b_level
);

  logic in_beat;
  assign in_beat = in_push && !in_full;

  // reset leaves the result queue empty and the input queue not full
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");

  // input side only fills up after a beat went in
  a_full_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_full) |-> $past(in_beat))
    else $error("input queue full without a beat");

  // with nothing in flight no result can appear
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && out_empty && $past(out_empty) && !in_beat && !$past(in_beat))
      |=> out_empty)
    else $error("result appeared with no item in flight");

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_light_level) &&
      $stable(out_vibe_level) && $stable(out_led_a_level) && $stable(out_led_b_level)))
    else $error("waiting result changed or vanished");

endmodule

bind haptic_and_led_pattern_driver hlpd_checker u_hlpd_checker (.*);

`default_nettype wire

>>> tb/haptic_and_led_pattern_driver_test.sv
`default_nettype none

module haptic_and_led_pattern_driver_test;
  import hlpd_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam logic [7:0] CMD_LED_BLINKA = 8'h33;
  localparam int unsigned SETTLE_LIMIT = 20000;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] cmd;
  } pin_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic [1:0] in_op = OP_CMD;
  logic [7:0] in_cmd = 8'h00;
  logic out_pop = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_BEEP_TICKS;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic in_full;
  logic out_empty;
  logic out_light_level;
  logic out_vibe_level;
  logic out_led_a_level;
  logic out_led_b_level;

  always #1 clk = ~clk;

  haptic_and_led_pattern_driver uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_op           (in_op),
    .in_cmd          (in_cmd),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_light_level (out_light_level),
    .out_vibe_level  (out_vibe_level),
    .out_led_a_level (out_led_a_level),
    .out_led_b_level (out_led_b_level),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  // own copy of the block's registers and state, matching its reset
  logic [11:0] beep_len = BEEP_TICKS_RST;
  logic [11:0] gap_len = BEEP_GAP_RST;
  logic [13:0] boop_len = BOOP_TICKS_RST;
  logic [15:0] tick_cnt = '0;
  logic [15:0] vibe_from = '0;
  logic [1:0] vibe_pat = VIBE_IDLE;
  logic [2:0] led_sel = LED_BLINKA;
  logic [11:0] pat_cnt = '0;
  logic [8:0] duty_lvl = '0;
  logic [7:0] pwm_ph = '0;
  hlpd_pins_t pins_now = '{light: 1'b0, vibe: 1'b0, led_a: 1'b1, led_b: 1'b1};

  logic [7:0] known_cmds [10] = '{CMD_LIGHT_LO, CMD_LIGHT_HI, CMD_BEEP, CMD_BOOP,
                                  CMD_LED_OFF, CMD_LED_ON, CMD_LED_PULSE,
                                  CMD_LED_BLINKA, CMD_LED_BLINKB, CMD_BEEP};

  hlpd_pins_t pins_due[$];
  pin_item_t beats_to_send[$];
  pin_item_t next_beat;
  hlpd_pins_t want;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic recv_hold = 1'b0;
  int phase_no = 0;
  int mismatches = 0;
  int n_cmds = 0;
  int n_pticks = 0;
  int n_pwm = 0;
  int n_other = 0;
  int n_results = 0;
  int n_full_stalls = 0;

  task automatic predict_pins(input logic [1:0] op, input logic [7:0] cmd);
    logic [15:0] elapsed;
    int unsigned el, b, g, bo, step, cycle, d, pc;
    logic lvl;
    b = beep_len;
    g = gap_len;
    bo = boop_len;
    case (op)
      OP_CMD: begin
        if (cmd == CMD_LIGHT_LO) begin
          pins_now.light = 1'b0;
        end else if (cmd == CMD_LIGHT_HI) begin
          pins_now.light = 1'b1;
        end else if (cmd == CMD_BEEP) begin
          // a beep request while any pattern runs is dropped
          if (vibe_pat == VIBE_IDLE) begin
            vibe_pat = VIBE_BEEP;
            vibe_from = tick_cnt;
          end
        end else if (cmd == CMD_BOOP) begin
          vibe_pat = VIBE_BOOP;
          vibe_from = tick_cnt;
        end else if (cmd == CMD_LED_OFF || cmd == CMD_LED_ON) begin
          led_sel = 3'(cmd - CMD_LED_OFF);
        end else if (cmd >= CMD_LED_PULSE && cmd <= CMD_LED_BLINKB) begin
          led_sel = 3'(cmd - CMD_LED_OFF);
          pat_cnt = '0;
          duty_lvl = DUTY_FULL;
          pwm_ph = '0;
        end
      end
      OP_PTICK: begin
        elapsed = tick_cnt - vibe_from;
        el = elapsed;
        if (vibe_pat == VIBE_BEEP) begin
          pins_now.vibe = (el < b) || (el > b + g && el < 2 * b + g);
          // may finish during the second pulse with the pin left high
          if (el > 3 * b) vibe_pat = VIBE_IDLE;
        end else if (vibe_pat == VIBE_BOOP) begin
          pins_now.vibe = (el < bo);
          if (el > bo) vibe_pat = VIBE_IDLE;
        end
        case (led_sel)
          LED_OFF: begin
            pins_now.led_a = 1'b1;
            pins_now.led_b = 1'b1;
          end
          LED_ON: begin
            pins_now.led_a = 1'b0;
            pins_now.led_b = 1'b0;
          end
          LED_PULSE, LED_BLINKA, LED_BLINKB: begin
            step = (led_sel == LED_PULSE) ? PULSE_STEP : BLINK_STEP;
            cycle = (led_sel == LED_PULSE) ? PULSE_CYCLE : BLINK_CYCLE;
            d = duty_lvl;
            pc = pat_cnt;
            if (pc == 0) begin
              duty_lvl = DUTY_FULL;
            end else if (pc % step == 0) begin
              duty_lvl = 9'(d * 3 / 4);
            end
            pat_cnt = 12'((pc + 1) % cycle);
          end
          default: ;
        endcase
        tick_cnt = tick_cnt + 16'd1;
      end
      OP_PWM: begin
        if (led_sel == LED_PULSE || led_sel == LED_BLINKA || led_sel == LED_BLINKB) begin
          lvl = !({1'b0, pwm_ph} < duty_lvl);
          if (led_sel != LED_BLINKB) pins_now.led_a = lvl;
          if (led_sel != LED_BLINKA) pins_now.led_b = lvl;
        end
        pwm_ph = pwm_ph + 8'd1;
      end
      default: ;
    endcase
    pins_due.push_back(pins_now);
  endtask

  task automatic check_pin(input string pin, input logic exp_v, input logic act_v);
    if (act_v !== exp_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0b got %0b", $time, pin, exp_v, act_v);
    end
  endtask

  // driver: a refused beat is held until the block takes it
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        predict_pins(in_op, in_cmd);
        case (in_op)
          OP_CMD: n_cmds++;
          OP_PTICK: n_pticks++;
          OP_PWM: n_pwm++;
          default: n_other++;
        endcase
      end
      if (in_push && in_full) begin
        n_full_stalls++;
      end else if (beats_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_beat = beats_to_send.pop_front();
        in_push <= 1'b1;
        in_op <= next_beat.op;
        in_cmd <= next_beat.cmd;
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        n_results++;
        if (pins_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result beat, expected none got %b", $time,
                   {out_light_level, out_vibe_level, out_led_a_level, out_led_b_level});
        end else begin
          want = pins_due.pop_front();
          check_pin("light_level", want.light, out_light_level);
          check_pin("vibe_level", want.vibe, out_vibe_level);
          check_pin("led_a_level", want.led_a, out_led_a_level);
          check_pin("led_b_level", want.led_b, out_led_b_level);
        end
      end
      out_pop <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // long receiver hold-off so the block backs up and refuses beats
  initial begin
    wait (phase_no == 3);
    repeat (20) @(posedge clk);
    recv_hold <= 1'b1;
    repeat (300) @(posedge clk);
    recv_hold <= 1'b0;
  end

  initial begin
    #400000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic add_beat(input logic [1:0] op, input logic [7:0] cmd);
    pin_item_t item;
    item.op = op;
    item.cmd = cmd;
    beats_to_send.push_back(item);
  endtask

  task automatic settle();
    int unsigned waited;
    waited = 0;
    while ((beats_to_send.size() != 0 || in_push || pins_due.size() != 0)
           && waited < SETTLE_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic run_phase(input logic [11:0] bt, input logic [11:0] gp,
                           input logic [13:0] bo, input int n, input int cmd_pct,
                           input int s_idle, input int r_idle);
    pin_item_t item;
    int unsigned roll;
    settle();
    write_reg(CFG_BEEP_TICKS, CFG_W'(bt));
    write_reg(CFG_BEEP_GAP, CFG_W'(gp));
    write_reg(CFG_BOOP_TICKS, bo);
    cfg_we <= 1'b0;
    beep_len = bt;
    gap_len = gp;
    boop_len = bo;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    phase_no++;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      item.cmd = 8'($urandom);
      if (roll < cmd_pct) begin
        item.op = OP_CMD;
        item.cmd = known_cmds[$urandom_range(9)];
      end else if (roll < cmd_pct + 4) begin
        // noise: mostly unknown command bytes and the unused op
        item.op = ($urandom_range(1) != 0) ? OP_CMD : OP_NONE;
      end else begin
        item.op = ($urandom_range(1) != 0) ? OP_PTICK : OP_PWM;
      end
      beats_to_send.push_back(item);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 9;
    recv_idle_pct = 69;

    // directed: reset led mode, ignored beats, every command, each led mode
    add_beat(OP_NONE, 8'hFF);
    add_beat(OP_CMD, 8'h00);
    add_beat(OP_CMD, 8'hFF);
    add_beat(OP_PWM, 8'hA5);
    add_beat(OP_PTICK, 8'h5A);
    add_beat(OP_PWM, 8'h00);
    add_beat(OP_CMD, CMD_LIGHT_HI);
    add_beat(OP_CMD, CMD_LIGHT_LO);
    add_beat(OP_CMD, CMD_LIGHT_HI);
    add_beat(OP_CMD, CMD_BOOP);
    add_beat(OP_PTICK, 8'h00);
    add_beat(OP_CMD, CMD_BEEP);
    add_beat(OP_CMD, CMD_LED_OFF);
    add_beat(OP_PTICK, 8'h00);
    add_beat(OP_CMD, CMD_LED_ON);
    add_beat(OP_PTICK, 8'h00);
    add_beat(OP_CMD, CMD_LED_PULSE);
    add_beat(OP_PWM, 8'h00);
    add_beat(OP_PTICK, 8'h00);
    add_beat(OP_PWM, 8'h00);
    add_beat(OP_CMD, CMD_LED_BLINKB);
    add_beat(OP_PTICK, 8'h00);
    add_beat(OP_PWM, 8'h00);
    add_beat(OP_CMD, CMD_LED_BLINKA);
    add_beat(OP_PWM, 8'h00);

    // gap a little over one beep, so the pattern can end with the motor on
    run_phase(12'd4, 12'd6, 14'd5, 140, 12, 9, 69);
    run_phase(12'd1, 12'd0, 14'd1, 140, 12, 9, 69);
    run_phase(12'd4095, 12'd4095, 14'd16383, 140, 12, 69, 9);
    // zero lengths never raise the motor pin
    run_phase(12'd0, 12'd0, 14'd0, 140, 12, 69, 9);
    run_phase(12'd3, 12'd7, 14'd12, 140, 6, 0, 0);
    run_phase(12'd50, 12'd50, 14'd200, 200, 3, 0, 0);

    settle();
    if (pins_due.size() != 0) begin
      mismatches++;
      $display("%0t: %0d expected result beats never arrived, expected 0 got %0d",
               $time, pins_due.size(), pins_due.size());
    end
    $display("covered %0d commands, %0d pattern ticks, %0d pwm ticks, %0d ignored ops",
             n_cmds, n_pticks, n_pwm, n_other);
    $display("checked %0d result beats over %0d register settings, %0d input stalls",
             n_results, phase_no + 1, n_full_stalls);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
